@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;
  localparam int STATUS_W = 2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    CMD_ENQ,
    CMD_DEQ
  } cmd_kind_t;

  // One classified command on its way from the front to the back.
  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [VALUE_W-1:0]  value;
    logic signed [PRIO_W-1:0]   prio;
  } cmd_t;

  // Queue handshake between the front and the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

@@ sv/spq_front.sv @@
`timescale 1ns / 1ps

module spq_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
  output spq_pkg::cmd_chan_t                  cmd_out,
  input  logic                                cmd_pop
);

  spq_pkg::cmd_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  spq_pkg::cmd_t in_cmd;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = cmd_pop && (fill != 2'd0);

  always_comb begin
    in_cmd.kind  = (opcode == spq_pkg::OP_DEQUEUE) ? spq_pkg::CMD_DEQ : spq_pkg::CMD_ENQ;
    in_cmd.value = item_value;
    in_cmd.prio  = item_priority;
  end

  assign cmd_out.valid = (fill != 2'd0);
  assign cmd_out.cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ sv/spq_back.sv @@
`timescale 1ns / 1ps

module spq_back #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spq_pkg::cmd_chan_t                  cmd_in,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
  output logic signed [spq_pkg::PRIO_W-1:0]   head_priority,
  output logic [spq_pkg::COUNT_W-1:0]         entry_count,
  output logic [spq_pkg::STATUS_W-1:0]        status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [spq_pkg::VALUE_W-1:0] cell_val      [CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0]  cell_pri      [CAPACITY];
  logic signed [spq_pkg::VALUE_W-1:0] cell_val_next [CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0]  cell_pri_next [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] ge_prev;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [CNT_W+4:0]   cnt_ext;
  logic               full;
  logic               empty;
  logic               fire;
  logic               do_enq;
  logic               do_deq;
  logic [spq_pkg::STATUS_W-1:0] status_next;

  assign full  = (cnt == CNT_W'(CAPACITY));
  assign empty = (cnt == '0);
  assign fire  = cmd_in.valid && (!out_valid || !out_stall);
  assign cmd_pop = fire;

  assign do_enq = fire && (cmd_in.cmd.kind == spq_pkg::CMD_ENQ) && !full;
  assign do_deq = fire && (cmd_in.cmd.kind == spq_pkg::CMD_DEQ) && !empty;

  // Each cell holds if its entry stays ahead of the new one.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < cnt) && (cell_pri[i] >= cmd_in.cmd.prio);
    end
    ge_prev[0] = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      ge_prev[i] = ge[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_val_next[i] = cell_val[i];
      cell_pri_next[i] = cell_pri[i];
    end
    if (do_enq) begin
      if (!ge[0]) begin
        cell_val_next[0] = cmd_in.cmd.value;
        cell_pri_next[0] = cmd_in.cmd.prio;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!ge[i]) begin
          if (ge_prev[i]) begin
            cell_val_next[i] = cmd_in.cmd.value;
            cell_pri_next[i] = cmd_in.cmd.prio;
          end else begin
            cell_val_next[i] = cell_val[i-1];
            cell_pri_next[i] = cell_pri[i-1];
          end
        end
      end
    end else if (do_deq) begin
      // Advance every entry one cell toward the head.
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cell_val_next[i] = cell_val[i+1];
        cell_pri_next[i] = cell_pri[i+1];
      end
    end
  end

  always_comb begin
    cnt_next    = cnt;
    status_next = spq_pkg::ST_DONE;
    if (cmd_in.cmd.kind == spq_pkg::CMD_ENQ) begin
      if (full) status_next = spq_pkg::ST_FULL;
      else      cnt_next    = cnt + CNT_W'(1);
    end else begin
      if (empty) status_next = spq_pkg::ST_EMPTY;
      else       cnt_next    = cnt - CNT_W'(1);
    end
  end

  assign cnt_ext = {5'd0, cnt_next};

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_val[i] <= cell_val_next[i];
      cell_pri[i] <= cell_pri_next[i];
    end
    if (fire) begin
      if (cnt_next == '0) begin
        head_value    <= '0;
        head_priority <= '0;
      end else begin
        head_value    <= cell_val_next[0];
        head_priority <= cell_pri_next[0];
      end
      entry_count <= cnt_ext[spq_pkg::COUNT_W-1:0];
      status      <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Word
// input     in_valid / in_stall   opcode, item_value, item_priority
// output    out_valid / out_stall head_value, head_priority, entry_count, status
//
// One item per cycle sustained while out_stall is low: a two-word command queue
// feeds a row of compare cells that inserts or pops, and the result word
// is registered at the edge at which the command leaves the queue.
// When nothing stalls, an accepted word passes through a command queue slot and then the result register.
// rst (synchronous) empties the command queue and the entry count.
// out_stall holds the result register; in_stall rises only when the queue is full.

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
  output logic signed [spq_pkg::PRIO_W-1:0]   head_priority,
  output logic [spq_pkg::COUNT_W-1:0]         entry_count,
  output logic [spq_pkg::STATUS_W-1:0]        status
);

  spq_pkg::cmd_chan_t cmd_chan;
  logic               cmd_pop;

  spq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .item_value    (item_value),
    .item_priority (item_priority),
    .cmd_out       (cmd_chan),
    .cmd_pop       (cmd_pop)
  );

  spq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_in        (cmd_chan),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .head_value    (head_value),
    .head_priority (head_priority),
    .entry_count   (entry_count),
    .status        (status)
  );

endmodule

@@ bench/queue_head_checker.sv @@
`timescale 1ns / 1ps

module queue_head_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                opcode,
  input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [spq_pkg::VALUE_W-1:0]  head_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]   head_priority,
  input  logic [spq_pkg::COUNT_W-1:0]         entry_count,
  input  logic [spq_pkg::STATUS_W-1:0]        status,
  output int                                  fault_count,
  output int                                  waiting
);

  typedef struct {
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic signed [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::COUNT_W-1:0]        count;
    logic [spq_pkg::STATUS_W-1:0]       code;
  } head_word_t;

  logic signed [spq_pkg::VALUE_W-1:0] model_value [CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0]  model_prio  [CAPACITY];
  int                        model_count = 0;
  head_word_t                expected_heads [$];
  head_word_t                want;
  int                        faults = 0;

  // Update the shadow queue with one command and return the head word it yields.
  function automatic head_word_t apply_queue_op(logic op,
                                                logic signed [spq_pkg::VALUE_W-1:0] v,
                                                logic signed [spq_pkg::PRIO_W-1:0] p);
    head_word_t w;
    int slot;
    w.code = spq_pkg::ST_DONE;
    if (op == spq_pkg::OP_ENQUEUE) begin
      if (model_count >= CAPACITY) begin
        w.code = spq_pkg::ST_FULL;
      end else begin
        // equal priorities stay in arrival order
        slot = 0;
        while (slot < model_count && model_prio[slot] >= p) slot++;
        for (int k = model_count; k > slot; k--) begin
          model_value[k] = model_value[k-1];
          model_prio[k]  = model_prio[k-1];
        end
        model_value[slot] = v;
        model_prio[slot]  = p;
        model_count++;
      end
    end else if (model_count == 0) begin
      w.code = spq_pkg::ST_EMPTY;
    end else begin
      for (int k = 0; k + 1 < model_count; k++) begin
        model_value[k] = model_value[k+1];
        model_prio[k]  = model_prio[k+1];
      end
      model_count--;
    end
    if (model_count > 0) begin
      w.value = model_value[0];
      w.prio  = model_prio[0];
    end else begin
      w.value = '0;
      w.prio  = '0;
    end
    w.count = model_count[spq_pkg::COUNT_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      model_count = 0;
      expected_heads.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_heads.push_back(apply_queue_op(opcode, item_value, item_priority));
      if (out_valid && !out_stall) begin
        if (expected_heads.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected head word: value %0d prio %0d count %0d status %0d",
                     head_value, head_priority, entry_count, status);
        end else begin
          want = expected_heads.pop_front();
          if (want.value !== head_value || want.prio !== head_priority ||
              want.count !== entry_count || want.code !== status) begin
            faults++;
            if (faults <= 10)
              $display("head mismatch: expected value %0d prio %0d count %0d status %0d,",
                       want.value, want.prio, want.count, want.code,
                       " got value %0d prio %0d count %0d status %0d",
                       head_value, head_priority, entry_count, status);
          end
        end
      end
    end
    fault_count <= faults;
    waiting     <= expected_heads.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CAPACITY = 16;
  localparam int RANDOM_WORDS = 1250;
  localparam int PRIO_W = spq_pkg::PRIO_W;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       opcode = spq_pkg::OP_ENQUEUE;
  logic signed [spq_pkg::VALUE_W-1:0]  item_value = '0;
  logic signed [PRIO_W-1:0]   item_priority = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [spq_pkg::VALUE_W-1:0]  head_value;
  logic signed [PRIO_W-1:0]   head_priority;
  logic [spq_pkg::COUNT_W-1:0]         entry_count;
  logic [spq_pkg::STATUS_W-1:0]        status;
  int                         fault_count;
  int                         waiting;

  int   burst_left = 0;
  bit   valid_dropped = 1'b1;
  int   enq_pct = 50;
  int   stall_mode = 0;
  int   stall_left = 0;
  logic op;

  sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (.*);
  queue_head_checker #(.CAPACITY(CAPACITY)) head_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver stall pattern: pick a new random mode and run length when the current run ends.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 6) < 2;
    endcase
  end

  // Hold the word until it is taken.
  task automatic send_word(logic kind, logic signed [spq_pkg::VALUE_W-1:0] v,
                           logic signed [PRIO_W-1:0] p);
    in_valid      <= 1'b1;
    opcode        <= kind;
    item_value    <= v;
    item_priority <= p;
    valid_dropped = 1'b0;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 9) >= 3) begin
        in_valid <= 1'b0;
        valid_dropped = 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [PRIO_W-1:0] random_prio();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return PRIO_W'(int'($urandom_range(0, 4)) - 2);
    if (pick < 7) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return PRIO_W'($urandom());
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // dequeue on empty, fields must be ignored
    send_word(spq_pkg::OP_DEQUEUE, 32'h7FFFFFFF, 16'h8000);
    send_word(spq_pkg::OP_ENQUEUE, 32'h7FFFFFFF, 16'h8000);
    send_word(spq_pkg::OP_ENQUEUE, 32'h80000000, 16'h7FFF);
    send_word(spq_pkg::OP_ENQUEUE, 32'h00000000, 16'h0000);
    send_word(spq_pkg::OP_ENQUEUE, 32'hFFFFFFFF, 16'hFFFF);
    send_word(spq_pkg::OP_ENQUEUE, 32'd1, 16'd5);
    send_word(spq_pkg::OP_ENQUEUE, 32'd2, 16'd5);
    send_word(spq_pkg::OP_ENQUEUE, 32'd3, 16'd5);
    send_word(spq_pkg::OP_ENQUEUE, 32'h55555555, 16'h7FFF);
    send_word(spq_pkg::OP_ENQUEUE, 32'hAAAAAAAA, 16'h8000);
    // fill to capacity, the last one is dropped
    for (int k = 9; k < CAPACITY + 1; k++)
      send_word(spq_pkg::OP_ENQUEUE, k, PRIO_W'(k % 3 - 1));
    send_word(spq_pkg::OP_DEQUEUE, 32'h80000000, 16'h7FFF);
    send_word(spq_pkg::OP_DEQUEUE, $urandom(), PRIO_W'($urandom()));
    send_word(spq_pkg::OP_DEQUEUE, 32'h0, 16'h0);

    // fill-heavy, drain-heavy and balanced stretches
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
      send_word(op, $urandom(), random_prio());
    end

    if (!valid_dropped) in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fault_count == 0 && waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
